// ===== hdl/aarm_pkg.sv =====
// ----------------------------------------------------------------------------
// Axis-angle rotation matrix: shared package
// Fixed-point constants, latencies, arctangent table and inter-module types.
// ----------------------------------------------------------------------------
`default_nettype none

package aarm_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int SQRT_STEPS   = 32;
	localparam int DIV_STEPS    = 31;

	// axis path: diff, normalize, square, sum, root steps, divide steps, sign
	localparam int AXIS_LAT   = 4 + SQRT_STEPS + DIV_STEPS + 1;
	// trig path: two range reductions, rotation steps, sign fix
	localparam int CORDIC_LAT = CORDIC_STEPS + 3;
	localparam int PAD_LAT    = AXIS_LAT - CORDIC_LAT;

	localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
	localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
	localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
	localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	typedef logic signed [31:0] unit_t;
	typedef logic signed [33:0] trig_t;

	typedef struct packed {
		logic  valid;
		logic  zero;
		unit_t nx;
		unit_t ny;
		unit_t nz;
	} axis_res_t;

	typedef struct packed {
		trig_t s;
		trig_t c;
	} trig_res_t;

	function automatic logic signed [33:0] atan_q30(input int i);
		logic signed [33:0] r;
		case (i)
			0:  r = 34'sh3243F6A8;
			1:  r = 34'sh1DAC6705;
			2:  r = 34'sh0FADBAFC;
			3:  r = 34'sh07F56EA6;
			4:  r = 34'sh03FEAB76;
			5:  r = 34'sh01FFD55B;
			6:  r = 34'sh00FFFAAA;
			7:  r = 34'sh007FFF55;
			8:  r = 34'sh003FFFEA;
			9:  r = 34'sh001FFFFD;
			10: r = 34'sh000FFFFF;
			11: r = 34'sh0007FFFF;
			12: r = 34'sh0003FFFF;
			13: r = 34'sh0001FFFF;
			14: r = 34'sh0000FFFF;
			15: r = 34'sh00007FFF;
			16: r = 34'sh00003FFF;
			17: r = 34'sh00001FFF;
			18: r = 34'sh00000FFF;
			19: r = 34'sh000007FF;
			20: r = 34'sh000003FF;
			21: r = 34'sh000001FF;
			22: r = 34'sh000000FF;
			23: r = 34'sh0000007F;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/axis_angle_rotation_matrix.sv =====
// ----------------------------------------------------------------------------
// Axis-angle rotation matrix
// Rodrigues 3x3 rotation matrix in Q1.14 from an angle and two axis points.
// ----------------------------------------------------------------------------
// The block takes one item per clock while in_stall is low and returns one
// matrix per item, in order. The delay through it is set by the axis path:
// a 32-stage square root followed by a 31-stage divider, one bit per stage;
// sine and cosine run alongside and are delayed to meet it. Three further
// stages form the products and the entries. When the result at the output is
// stalled the whole pipeline holds and in_stall rises in the same cycle.
// Coincident points set axis_invalid and give the identity matrix.
`default_nettype none

module axis_angle_rotation_matrix (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] angle,
	input  logic signed [31:0] point_a_x,
	input  logic signed [31:0] point_a_y,
	input  logic signed [31:0] point_a_z,
	input  logic signed [31:0] point_b_x,
	input  logic signed [31:0] point_b_y,
	input  logic signed [31:0] point_b_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] m00,
	output logic signed [15:0] m01,
	output logic signed [15:0] m02,
	output logic signed [15:0] m10,
	output logic signed [15:0] m11,
	output logic signed [15:0] m12,
	output logic signed [15:0] m20,
	output logic signed [15:0] m21,
	output logic signed [15:0] m22,
	output logic               axis_invalid
);
	import aarm_pkg::*;

	logic      en;
	axis_res_t ax;
	trig_res_t tr;

	assign in_stall = out_valid && out_stall;
	assign en       = !in_stall;

	aarm_axis u_axis (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.point_a_x (point_a_x),
		.point_a_y (point_a_y),
		.point_a_z (point_a_z),
		.point_b_x (point_b_x),
		.point_b_y (point_b_y),
		.point_b_z (point_b_z),
		.res       (ax)
	);

	aarm_cordic u_cordic (
		.clk   (clk),
		.en    (en),
		.angle (angle),
		.res   (tr)
	);

	// stage m1: n*n, n*s, t
	logic signed [63:0] pnn [6];
	logic signed [63:0] pns [3];
	logic signed [63:0] nnsh [6];
	logic signed [63:0] nssh [3];

	logic               v_m1, zero_m1;
	logic signed [31:0] nn_m1 [6];
	logic signed [34:0] ns_m1 [3];
	logic signed [33:0] t_m1, c_m1;

	always_comb begin
		pnn[0] = 64'(ax.nx) * 64'(ax.nx);
		pnn[1] = 64'(ax.nx) * 64'(ax.ny);
		pnn[2] = 64'(ax.nx) * 64'(ax.nz);
		pnn[3] = 64'(ax.ny) * 64'(ax.ny);
		pnn[4] = 64'(ax.ny) * 64'(ax.nz);
		pnn[5] = 64'(ax.nz) * 64'(ax.nz);
		pns[0] = 64'(ax.nx) * 64'(tr.s);
		pns[1] = 64'(ax.ny) * 64'(tr.s);
		pns[2] = 64'(ax.nz) * 64'(tr.s);
		for (int j = 0; j < 6; j++) nnsh[j] = pnn[j] >>> 30;
		for (int j = 0; j < 3; j++) nssh[j] = pns[j] >>> 30;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_m1 <= 1'b0;
		else if (en) v_m1 <= ax.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 6; j++) nn_m1[j] <= nnsh[j][31:0];
			for (int j = 0; j < 3; j++) ns_m1[j] <= nssh[j][34:0];
			t_m1    <= Q30_ONE - tr.c;
			c_m1    <= tr.c;
			zero_m1 <= ax.zero;
		end
	end

	// stage m2: (n*n)*t
	logic signed [63:0] ptp [6];
	logic signed [63:0] ptsh [6];

	logic               v_m2, zero_m2;
	logic signed [33:0] pt_m2 [6];
	logic signed [34:0] ns_m2 [3];
	logic signed [33:0] c_m2;

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			ptp[j]  = 64'(nn_m1[j]) * 64'(t_m1);
			ptsh[j] = ptp[j] >>> 30;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_m2 <= 1'b0;
		else if (en) v_m2 <= v_m1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 6; j++) pt_m2[j] <= ptsh[j][33:0];
			ns_m2   <= ns_m1;
			c_m2    <= c_m1;
			zero_m2 <= zero_m1;
		end
	end

	// stage m3: entries, round and saturate to Q1.14
	function automatic logic signed [15:0] to_q14(input logic signed [36:0] v);
		logic signed [37:0] r;
		logic signed [15:0] o;
		r = (38'(v) + 38'sd32768) >>> 16;
		if (r > 38'sd16384) o = 16'sd16384;
		else if (r < -38'sd16384) o = -16'sd16384;
		else o = r[15:0];
		return o;
	endfunction

	logic signed [36:0] c_e;
	logic signed [36:0] pt_e [6];
	logic signed [36:0] ns_e [3];

	always_comb begin
		c_e = 37'(c_m2);
		for (int j = 0; j < 6; j++) pt_e[j] = 37'(pt_m2[j]);
		for (int j = 0; j < 3; j++) ns_e[j] = 37'(ns_m2[j]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= v_m2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			axis_invalid <= zero_m2;
			if (zero_m2) begin
				m00 <= 16'sd16384;
				m01 <= '0;
				m02 <= '0;
				m10 <= '0;
				m11 <= 16'sd16384;
				m12 <= '0;
				m20 <= '0;
				m21 <= '0;
				m22 <= 16'sd16384;
			end else begin
				m00 <= to_q14(c_e + pt_e[0]);
				m01 <= to_q14(pt_e[1] - ns_e[2]);
				m02 <= to_q14(pt_e[2] + ns_e[1]);
				m10 <= to_q14(pt_e[1] + ns_e[2]);
				m11 <= to_q14(c_e + pt_e[3]);
				m12 <= to_q14(pt_e[4] - ns_e[0]);
				m20 <= to_q14(pt_e[2] - ns_e[1]);
				m21 <= to_q14(pt_e[4] + ns_e[0]);
				m22 <= to_q14(c_e + pt_e[5]);
			end
		end
	end

`ifndef ASSERT_OFF
	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && axis_invalid |-> m00 == 16'sd16384 && m11 == 16'sd16384 &&
			m22 == 16'sd16384 && m01 == 16'sd0 && m12 == 16'sd0 && m20 == 16'sd0)
		else $error("invalid axis without identity matrix");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> m00 <= 16'sd16384 && m00 >= -16'sd16384 &&
			m01 <= 16'sd16384 && m01 >= -16'sd16384)
		else $error("matrix entry out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(v_m2) && $stable(v_m1))
		else $error("pipeline moved while stalled");
`endif

endmodule

`default_nettype wire

// ===== hdl/aarm_axis.sv =====
// ----------------------------------------------------------------------------
// Axis unit vector pipeline
// Difference of the two points, common normalizing shift, sum of squares,
// one-bit-per-stage square root and three one-bit-per-stage dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module aarm_axis (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic signed [31:0]  point_a_x,
	input  logic signed [31:0]  point_a_y,
	input  logic signed [31:0]  point_a_z,
	input  logic signed [31:0]  point_b_x,
	input  logic signed [31:0]  point_b_y,
	input  logic signed [31:0]  point_b_z,
	output aarm_pkg::axis_res_t res
);
	import aarm_pkg::*;

	typedef logic [2:0][31:0] dvec_t;

	// stage 1: differences
	logic               v_s1;
	logic signed [32:0] d_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= 33'(point_b_x) - 33'(point_a_x);
			d_s1[1] <= 33'(point_b_y) - 33'(point_a_y);
			d_s1[2] <= 33'(point_b_z) - 33'(point_a_z);
		end
	end

	// stage 2: shift so that the largest magnitude lies in [2^30, 2^31)
	logic [32:0]        am [3];
	logic [32:0]        mag;
	logic [5:0]         msb;
	logic signed [32:0] rsh [3];
	logic signed [63:0] lsh [3];
	dvec_t              dn_c;
	logic               v_s2, zero_s2;
	dvec_t              dn_s2;

	always_comb begin
		mag = '0;
		msb = '0;
		for (int k = 0; k < 3; k++) begin
			am[k] = d_s1[k][32] ? 33'(-d_s1[k]) : d_s1[k];
			if (am[k] > mag) mag = am[k];
		end
		for (int i = 0; i < 33; i++) begin
			if (mag[i]) msb = 6'(i);
		end
		for (int k = 0; k < 3; k++) begin
			rsh[k] = d_s1[k] >>> (msb - 6'd30);
			lsh[k] = 64'(d_s1[k]) <<< (6'd30 - msb);
			dn_c[k] = (msb > 6'd30) ? rsh[k][31:0] : lsh[k][31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dn_s2   <= dn_c;
			zero_s2 <= (mag == '0);
		end
	end

	// stage 3: squares
	logic signed [63:0] sqp [3];
	logic [62:0]        sq_s3 [3];
	logic               v_s3, zero_s3;
	dvec_t              dn_s3;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sqp[k] = 64'($signed(dn_s2[k])) * 64'($signed(dn_s2[k]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) sq_s3[k] <= sqp[k][62:0];
			dn_s3   <= dn_s2;
			zero_s3 <= zero_s2;
		end
	end

	// stage 4: sum of squares
	logic [63:0] sum_s4;
	logic        v_s4, zero_s4;
	dvec_t       dn_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4  <= {1'b0, sq_s3[0]} + {1'b0, sq_s3[1]} + {1'b0, sq_s3[2]};
			dn_s4   <= dn_s3;
			zero_s4 <= zero_s3;
		end
	end

	// square root, one result bit per stage
	logic [63:0] rt_rad_i  [SQRT_STEPS];
	logic [33:0] rt_rem_i  [SQRT_STEPS];
	logic [31:0] rt_root_i [SQRT_STEPS];
	dvec_t       rt_dn_i   [SQRT_STEPS];
	logic        rt_zero_i [SQRT_STEPS];
	logic        rt_v_i    [SQRT_STEPS];

	logic [63:0] rt_rad_s  [SQRT_STEPS];
	logic [33:0] rt_rem_s  [SQRT_STEPS];
	logic [31:0] rt_root_s [SQRT_STEPS];
	dvec_t       rt_dn_s   [SQRT_STEPS];
	logic        rt_zero_s [SQRT_STEPS];
	logic        rt_v_s    [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		logic [35:0] cur;
		logic [35:0] trial;
		logic        ge;

		if (k == 0) begin : g_first
			assign rt_rad_i[k]  = sum_s4;
			assign rt_rem_i[k]  = '0;
			assign rt_root_i[k] = '0;
			assign rt_dn_i[k]   = dn_s4;
			assign rt_zero_i[k] = zero_s4;
			assign rt_v_i[k]    = v_s4;
		end else begin : g_next
			assign rt_rad_i[k]  = rt_rad_s[k-1];
			assign rt_rem_i[k]  = rt_rem_s[k-1];
			assign rt_root_i[k] = rt_root_s[k-1];
			assign rt_dn_i[k]   = rt_dn_s[k-1];
			assign rt_zero_i[k] = rt_zero_s[k-1];
			assign rt_v_i[k]    = rt_v_s[k-1];
		end

		assign cur   = {rt_rem_i[k], rt_rad_i[k][63:62]};
		assign trial = {2'b00, rt_root_i[k], 2'b01};
		assign ge    = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rt_v_s[k] <= 1'b0;
			else if (en) rt_v_s[k] <= rt_v_i[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_rad_s[k]  <= {rt_rad_i[k][61:0], 2'b00};
				rt_rem_s[k]  <= ge ? 34'(cur - trial) : cur[33:0];
				rt_root_s[k] <= {rt_root_i[k][30:0], ge};
				rt_dn_s[k]   <= rt_dn_i[k];
				rt_zero_s[k] <= rt_zero_i[k];
			end
		end
	end

	// unit components: |d| * 2^30 / norm, one quotient bit per stage
	logic [2:0][31:0] dv_rem_i  [DIV_STEPS];
	logic [2:0]       dv_bit_i  [DIV_STEPS];
	logic [2:0][30:0] dv_q_i    [DIV_STEPS];
	logic [2:0]       dv_neg_i  [DIV_STEPS];
	logic [31:0]      dv_norm_i [DIV_STEPS];
	logic             dv_zero_i [DIV_STEPS];
	logic             dv_v_i    [DIV_STEPS];

	logic [2:0][31:0] dv_rem_s  [DIV_STEPS];
	logic [2:0][30:0] dv_q_s    [DIV_STEPS];
	logic [2:0]       dv_neg_s  [DIV_STEPS];
	logic [31:0]      dv_norm_s [DIV_STEPS];
	logic             dv_zero_s [DIV_STEPS];
	logic             dv_v_s    [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [2:0][32:0] cur;
		logic [2:0]       ge;

		if (k == 0) begin : g_first
			logic [2:0][31:0] amag;
			for (genvar l = 0; l < 3; l++) begin : g_lane
				assign amag[l] = rt_dn_s[SQRT_STEPS-1][l][31] ?
					32'(-rt_dn_s[SQRT_STEPS-1][l]) : rt_dn_s[SQRT_STEPS-1][l];
				assign dv_rem_i[k][l] = {1'b0, amag[l][31:1]};
				assign dv_bit_i[k][l] = amag[l][0];
				assign dv_neg_i[k][l] = rt_dn_s[SQRT_STEPS-1][l][31];
			end
			assign dv_q_i[k]    = '0;
			assign dv_norm_i[k] = rt_root_s[SQRT_STEPS-1];
			assign dv_zero_i[k] = rt_zero_s[SQRT_STEPS-1];
			assign dv_v_i[k]    = rt_v_s[SQRT_STEPS-1];
		end else begin : g_next
			assign dv_rem_i[k]  = dv_rem_s[k-1];
			assign dv_bit_i[k]  = '0;
			assign dv_q_i[k]    = dv_q_s[k-1];
			assign dv_neg_i[k]  = dv_neg_s[k-1];
			assign dv_norm_i[k] = dv_norm_s[k-1];
			assign dv_zero_i[k] = dv_zero_s[k-1];
			assign dv_v_i[k]    = dv_v_s[k-1];
		end

		for (genvar l = 0; l < 3; l++) begin : g_cmp
			assign cur[l] = {dv_rem_i[k][l], dv_bit_i[k][l]};
			assign ge[l]  = (cur[l] >= {1'b0, dv_norm_i[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[k] <= 1'b0;
			else if (en) dv_v_s[k] <= dv_v_i[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 3; l++) begin
					dv_rem_s[k][l] <= ge[l] ? 32'(cur[l] - {1'b0, dv_norm_i[k]}) :
						cur[l][31:0];
					dv_q_s[k][l] <= {dv_q_i[k][l][29:0], ge[l]};
				end
				dv_neg_s[k]  <= dv_neg_i[k];
				dv_norm_s[k] <= dv_norm_i[k];
				dv_zero_s[k] <= dv_zero_i[k];
			end
		end
	end

	// final stage: apply signs
	logic [2:0][31:0] qe;
	logic [2:0][31:0] nsgn;
	logic             fin_v_s;
	logic             fin_zero_s;
	logic [2:0][31:0] fin_n_s;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			qe[l]   = {1'b0, dv_q_s[DIV_STEPS-1][l]};
			nsgn[l] = dv_neg_s[DIV_STEPS-1][l] ? 32'(-qe[l]) : qe[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fin_v_s <= 1'b0;
		else if (en) fin_v_s <= dv_v_s[DIV_STEPS-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_n_s    <= nsgn;
			fin_zero_s <= dv_zero_s[DIV_STEPS-1];
		end
	end

	assign res.valid = fin_v_s;
	assign res.zero  = fin_zero_s;
	assign res.nx    = $signed(fin_n_s[0]);
	assign res.ny    = $signed(fin_n_s[1]);
	assign res.nz    = $signed(fin_n_s[2]);

endmodule

`default_nettype wire

// ===== hdl/aarm_cordic.sv =====
// ----------------------------------------------------------------------------
// Sine and cosine pipeline
// Range reduction to [-pi/2, pi/2], one rotation step per stage, sign fix,
// then a delay line that lines the result up with the axis path.
// ----------------------------------------------------------------------------
`default_nettype none

module aarm_cordic (
	input  logic                clk,
	input  logic                en,
	input  logic signed [15:0]  angle,
	output aarm_pkg::trig_res_t res
);
	import aarm_pkg::*;

	// reduce into [-pi, pi]
	logic signed [35:0] z0;
	logic signed [35:0] z_c1;

	assign z0 = 36'(angle) <<< 18;

	always_ff @(posedge clk) begin
		if (en) begin
			if (z0 > Q30_PI) z_c1 <= z0 - Q30_TWO_PI;
			else if (z0 < -Q30_PI) z_c1 <= z0 + Q30_TWO_PI;
			else z_c1 <= z0;
		end
	end

	// reduce into [-pi/2, pi/2]
	logic signed [35:0] zt;
	logic               ng_c;
	logic signed [33:0] z_c2;
	logic               ng_c2;

	always_comb begin
		zt   = z_c1;
		ng_c = 1'b0;
		if (z_c1 > Q30_HALF_PI) begin
			zt   = z_c1 - Q30_PI;
			ng_c = 1'b1;
		end else if (z_c1 < -Q30_HALF_PI) begin
			zt   = z_c1 + Q30_PI;
			ng_c = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_c2  <= zt[33:0];
			ng_c2 <= ng_c;
		end
	end

	// rotation steps
	logic signed [33:0] x_i [CORDIC_STEPS];
	logic signed [33:0] y_i [CORDIC_STEPS];
	logic signed [33:0] z_i [CORDIC_STEPS];
	logic               n_i [CORDIC_STEPS];
	logic signed [33:0] x_st [CORDIC_STEPS];
	logic signed [33:0] y_st [CORDIC_STEPS];
	logic signed [33:0] z_st [CORDIC_STEPS];
	logic               n_st [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [33:0] xs;
		logic signed [33:0] ys;
		logic signed [33:0] at;

		if (i == 0) begin : g_first
			assign x_i[i] = CORDIC_GAIN;
			assign y_i[i] = '0;
			assign z_i[i] = z_c2;
			assign n_i[i] = ng_c2;
		end else begin : g_next
			assign x_i[i] = x_st[i-1];
			assign y_i[i] = y_st[i-1];
			assign z_i[i] = z_st[i-1];
			assign n_i[i] = n_st[i-1];
		end

		assign xs = x_i[i] >>> i;
		assign ys = y_i[i] >>> i;
		assign at = atan_q30(i);

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_i[i][33]) begin
					x_st[i] <= x_i[i] - ys;
					y_st[i] <= y_i[i] + xs;
					z_st[i] <= z_i[i] - at;
				end else begin
					x_st[i] <= x_i[i] + ys;
					y_st[i] <= y_i[i] - xs;
					z_st[i] <= z_i[i] + at;
				end
				n_st[i] <= n_i[i];
			end
		end
	end

	// sign fix
	trig_res_t out_c;

	always_ff @(posedge clk) begin
		if (en) begin
			out_c.s <= n_st[CORDIC_STEPS-1] ? -y_st[CORDIC_STEPS-1] : y_st[CORDIC_STEPS-1];
			out_c.c <= n_st[CORDIC_STEPS-1] ? -x_st[CORDIC_STEPS-1] : x_st[CORDIC_STEPS-1];
		end
	end

	// alignment delay
	trig_res_t dl_q [PAD_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			dl_q[0] <= out_c;
			for (int j = 1; j < PAD_LAT; j++) dl_q[j] <= dl_q[j-1];
		end
	end

	assign res = dl_q[PAD_LAT-1];

endmodule

`default_nettype wire
